// File: rtl/ikl_pkg.sv
package ikl_pkg;

  // Field widths of the ports
  localparam int COORD_W  = 24;
  localparam int ANGLE_W  = 16;
  localparam int LINK_W   = 23;
  localparam int OFFSET_W = 24;
  localparam int CFG_W    = 24;

  // Internal angle format Q3.29 and the CORDIC datapath width
  localparam int ANG_FRAC = 29;
  localparam int CD_W     = 34;
  localparam int OPND_W   = 31;
  localparam int TAB_LEN  = 24;

  // Square root: 60-bit radicand, one result bit per stage
  localparam int RAD_W     = 60;
  localparam int ROOT_W    = 30;
  localparam int SQ_STAGES = 30;

  localparam logic signed [CD_W-1:0] PI_Q29 = 34'sd1686629713;

  localparam logic signed [CD_W-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
    34'sd33510843,  34'sd16771758,  34'sd8387925,   34'sd4194219,
    34'sd2097141,   34'sd1048575,   34'sd524288,    34'sd262144,
    34'sd131072,    34'sd65536,     34'sd32768,     34'sd16384,
    34'sd8192,      34'sd4096,      34'sd2048,      34'sd1024,
    34'sd512,       34'sd256,       34'sd128,       34'sd64
  };

  // Output rounding from Q3.29 to Q3.(ANGLE_W-3)
  localparam int ANG_SH = ANG_FRAC - (ANGLE_W - 3);
  localparam logic signed [CD_W-1:0] ANG_HALF = CD_W'(1) <<< (ANG_SH - 1);
  localparam logic signed [CD_W-1:0] ANG_LIM  = (PI_Q29 + ANG_HALF) >>> ANG_SH;

  // Configuration register indexes
  localparam logic [1:0] REG_UPPER  = 2'd0;
  localparam logic [1:0] REG_LOWER  = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    ST_SOLVED   = 2'd0,
    ST_CLAMPED  = 2'd1,
    ST_SINGULAR = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
  } target_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] shoulder_angle;
    logic signed [ANGLE_W-1:0] elbow_angle;
    status_t                   solve_status;
  } result_t;

  // Side data that rides through the square root pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W:0]    y;
    logic signed [OPND_W-1:0]   a_s;
    logic [ROOT_W-1:0]          bm;
    logic                       aneg;
    logic                       clamped;
  } sq_tag_t;

  // Side data that rides through the CORDIC pipelines
  typedef struct packed {
    logic clamped;
    logic aneg;
    logic singular;
  } cd_tag_t;

  // Right shift that brings a magnitude below 2^bits
  function automatic logic [6:0] shrink_k(input logic [63:0] m, input logic [6:0] bits);
    logic [6:0] len;
    len = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) len = 7'(i + 1);
    end
    return (len > bits) ? 7'(len - bits) : 7'd0;
  endfunction

  // Round half up to the output format and limit to +-pi
  function automatic logic [ANGLE_W-1:0] to_angle(input logic signed [CD_W-1:0] z);
    logic signed [CD_W-1:0] r;
    r = (z + ANG_HALF) >>> ANG_SH;
    if (r > ANG_LIM) r = ANG_LIM;
    if (r < -ANG_LIM) r = -ANG_LIM;
    return r[ANGLE_W-1:0];
  endfunction

endpackage

// File: rtl/ikl_isqrt.sv
module ikl_isqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [ikl_pkg::RAD_W-1:0]         in_rad,
  input  ikl_pkg::sq_tag_t                  in_tag,
  output logic                              out_valid,
  output logic [ikl_pkg::ROOT_W-1:0]        out_root,
  output ikl_pkg::sq_tag_t                  out_tag
);

  localparam int N = ikl_pkg::SQ_STAGES;
  localparam int W = ikl_pkg::RAD_W;

  logic [W-1:0]     vv  [N+1];
  logic [W-1:0]     rr  [N+1];
  ikl_pkg::sq_tag_t tg  [N+1];
  logic [N:0]       vld;

  assign vv[0]  = in_rad;
  assign rr[0]  = '0;
  assign tg[0]  = in_tag;
  assign vld[0] = in_valid;

  // One root bit per stage, restoring
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2*i);
    logic [W:0] trial;
    assign trial = {1'b0, rr[i]} + BIT;

    always_ff @(posedge clk) begin
      if ({1'b0, vv[i]} >= trial) begin
        vv[i+1] <= W'({1'b0, vv[i]} - trial);
        rr[i+1] <= W'({1'b0, rr[i] >> 1} + BIT);
      end else begin
        vv[i+1] <= vv[i];
        rr[i+1] <= rr[i] >> 1;
      end
      tg[i+1] <= tg[i];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[N];
  assign out_root  = rr[N][ikl_pkg::ROOT_W-1:0];
  assign out_tag   = tg[N];

endmodule

// File: rtl/ikl_cordic.sv
module ikl_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [ikl_pkg::OPND_W-1:0]      in_y,
  input  logic signed [ikl_pkg::OPND_W-1:0]      in_x,
  input  ikl_pkg::cd_tag_t                       in_tag,
  output logic                                   out_valid,
  output logic signed [ikl_pkg::CD_W-1:0]        out_z,
  output ikl_pkg::cd_tag_t                       out_tag
);

  localparam int W = ikl_pkg::CD_W;

  logic signed [W-1:0] xs [STAGES+1];
  logic signed [W-1:0] ys [STAGES+1];
  logic signed [W-1:0] zs [STAGES+1];
  logic                zr [STAGES+1];
  ikl_pkg::cd_tag_t    tg [STAGES+1];
  logic [STAGES:0]     vld;

  // Fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (in_x < 0) begin
      xs[0] <= -W'(in_x);
      ys[0] <= -W'(in_y);
      zs[0] <= (in_y >= 0) ? ikl_pkg::PI_Q29 : -ikl_pkg::PI_Q29;
    end else begin
      xs[0] <= W'(in_x);
      ys[0] <= W'(in_y);
      zs[0] <= '0;
    end
    zr[0] <= (in_x == 0) && (in_y == 0);
    tg[0] <= in_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
  end

  // Vectoring: drive y toward zero, one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ikl_pkg::ATAN_TAB[i];
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ikl_pkg::ATAN_TAB[i];
      end
      zr[i+1] <= zr[i];
      tg[i+1] <= tg[i];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[STAGES];
  assign out_z     = zr[STAGES] ? '0 : zs[STAGES];
  assign out_tag   = tg[STAGES];

endmodule

// File: rtl/two_link_inverse_kinematics_unit.sv
// Two-link planar arm inverse kinematics, fully pipelined. One target is
// taken per clock (busy stays low) and its result is strobed on result_valid
// for one cycle; the receiver cannot hold results off, so it must take
// every beat. Latency is set by the 30-stage square root and the two
// parallel CORDIC atan2 units.
// Write the link lengths and base offset only while no target is in flight.
module two_link_inverse_kinematics_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  ikl_pkg::target_t                  target,
  output logic                              result_valid,
  output ikl_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ikl_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW = ikl_pkg::COORD_W;
  localparam int LW = ikl_pkg::LINK_W;
  localparam int OW = ikl_pkg::OPND_W;

  // Configuration registers
  logic [LW-1:0]                     l1;
  logic [LW-1:0]                     l2;
  logic signed [ikl_pkg::OFFSET_W-1:0] y_off;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1    <= LW'(4096);
      l2    <= LW'(4096);
      y_off <= ikl_pkg::OFFSET_W'(8192);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ikl_pkg::REG_UPPER:  l1 <= cfg_data[LW-1:0];
        ikl_pkg::REG_LOWER:  l2 <= cfg_data[LW-1:0];
        ikl_pkg::REG_OFFSET: y_off <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front pipeline valid bits
  logic [8:0] vp;
  always_ff @(posedge clk) begin
    if (rst) vp <= '0;
    else vp <= {vp[7:0], start && !busy};
  end

  logic signed [CW-1:0] x_p [9];
  logic signed [CW:0]   y_p [9];

  // Take the beat, add the base offset
  always_ff @(posedge clk) begin
    x_p[0] <= target.target_x;
    y_p[0] <= (CW+1)'(target.target_y) + (CW+1)'(y_off);
  end

  for (genvar i = 1; i < 9; i++) begin : g_xy
    always_ff @(posedge clk) begin
      x_p[i] <= x_p[i-1];
      y_p[i] <= y_p[i-1];
    end
  end

  // Magnitudes
  logic [CW-1:0] ux_p1;
  logic [CW:0]   uy_p1;
  always_ff @(posedge clk) begin
    ux_p1 <= x_p[0][CW-1] ? CW'(-x_p[0]) : CW'(x_p[0]);
    uy_p1 <= y_p[0][CW] ? (CW+1)'(-y_p[0]) : (CW+1)'(y_p[0]);
  end

  // Squares and link product
  logic [47:0] xsq_p2;
  logic [48:0] ysq_p2;
  logic [45:0] l1sq_p2, l2sq_p2, l12_p2;
  always_ff @(posedge clk) begin
    xsq_p2  <= ux_p1 * ux_p1;
    ysq_p2  <= 49'(uy_p1 * uy_p1);
    l1sq_p2 <= l1 * l1;
    l2sq_p2 <= l2 * l2;
    l12_p2  <= l1 * l2;
  end

  // d^2, L1^2+L2^2, b
  logic [48:0] d2_p3;
  logic [46:0] s_p3, b_p3;
  always_ff @(posedge clk) begin
    d2_p3 <= 49'(xsq_p2) + ysq_p2;
    s_p3  <= 47'(l1sq_p2) + 47'(l2sq_p2);
    b_p3  <= {l12_p2, 1'b0};
  end

  // |a| and its sign
  logic [48:0] amag_p4;
  logic [46:0] b_p4;
  logic        aneg_p4;
  always_ff @(posedge clk) begin
    aneg_p4 <= d2_p3 < 49'(s_p3);
    amag_p4 <= (d2_p3 < 49'(s_p3)) ? 49'(s_p3) - d2_p3 : d2_p3 - 49'(s_p3);
    b_p4    <= b_p3;
  end

  // Reach test and common scale
  logic [48:0] amag_p5;
  logic [46:0] b_p5;
  logic        aneg_p5, clamped_p5;
  logic [6:0]  k_p5;
  always_ff @(posedge clk) begin
    clamped_p5 <= amag_p4 > 49'(b_p4);
    k_p5       <= ikl_pkg::shrink_k(64'(amag_p4 | 49'(b_p4)), 7'd30);
    amag_p5    <= amag_p4;
    b_p5       <= b_p4;
    aneg_p5    <= aneg_p4;
  end

  logic [29:0] am_p6, bm_p6;
  logic        aneg_p6, clamped_p6;
  always_ff @(posedge clk) begin
    am_p6      <= 30'(amag_p5 >> k_p5);
    bm_p6      <= 30'(b_p5 >> k_p5);
    aneg_p6    <= aneg_p5;
    clamped_p6 <= clamped_p5;
  end

  logic [59:0] bsq_p7, asq_p7;
  logic [29:0] am_p7, bm_p7;
  logic        aneg_p7, clamped_p7;
  always_ff @(posedge clk) begin
    bsq_p7     <= bm_p6 * bm_p6;
    asq_p7     <= am_p6 * am_p6;
    am_p7      <= am_p6;
    bm_p7      <= bm_p6;
    aneg_p7    <= aneg_p6;
    clamped_p7 <= clamped_p6;
  end

  // Radicand b^2 - a^2
  logic [59:0]      rad_p8;
  ikl_pkg::sq_tag_t sqt_p8;
  always_ff @(posedge clk) begin
    rad_p8         <= bsq_p7 - asq_p7;
    sqt_p8.x       <= x_p[7];
    sqt_p8.y       <= y_p[7];
    sqt_p8.a_s     <= aneg_p7 ? -OW'(am_p7) : OW'(am_p7);
    sqt_p8.bm      <= bm_p7;
    sqt_p8.aneg    <= aneg_p7;
    sqt_p8.clamped <= clamped_p7;
  end

  logic                  sq_vld;
  logic [29:0]           sq_root;
  ikl_pkg::sq_tag_t      sq_tag;

  ikl_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vp[8]),
    .in_rad    (rad_p8),
    .in_tag    (sqt_p8),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // Back pipeline: side data shift line
  logic [8:0]       vq;
  ikl_pkg::sq_tag_t tq [9];
  logic [29:0]      sr_q [9];
  assign vq[0]   = sq_vld;
  assign tq[0]   = sq_tag;
  assign sr_q[0] = sq_root;

  for (genvar i = 1; i < 9; i++) begin : g_q
    always_ff @(posedge clk) begin
      tq[i]   <= tq[i-1];
      sr_q[i] <= sr_q[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) vq[i] <= 1'b0;
      else vq[i] <= vq[i-1];
    end
  end

  // kc and ks products
  logic [52:0]        m1_q1, m3_q1;
  logic signed [53:0] m2_q1;
  always_ff @(posedge clk) begin
    m1_q1 <= l1 * tq[0].bm;
    m2_q1 <= $signed({1'b0, l2}) * tq[0].a_s;
    m3_q1 <= l2 * sr_q[0];
  end

  logic signed [54:0] kc_q2;
  logic [52:0]        ks_q2;
  always_ff @(posedge clk) begin
    if (tq[1].clamped) begin
      kc_q2 <= tq[1].aneg ? 55'($signed({1'b0, l1})) - 55'($signed({1'b0, l2}))
                          : 55'($signed({1'b0, l1})) + 55'($signed({1'b0, l2}));
      ks_q2 <= '0;
    end else begin
      kc_q2 <= $signed({2'b0, m1_q1}) + 55'(m2_q1);
      ks_q2 <= m3_q1;
    end
  end

  // Singular test and scale kc, ks below 2^28
  logic [53:0] kcm;
  assign kcm = kc_q2[54] ? 54'(-kc_q2) : 54'(kc_q2);

  logic [53:0] kcm_q3;
  logic [52:0] ks_q3;
  logic        kcn_q3;
  logic [6:0]  k_q3;
  logic [5:3]  sing_q;
  always_ff @(posedge clk) begin
    kcm_q3    <= kcm;
    kcn_q3    <= kc_q2[54];
    ks_q3     <= ks_q2;
    k_q3      <= ikl_pkg::shrink_k(64'(kcm | 54'(ks_q2)), 7'd28);
    sing_q[3] <= (kc_q2 == '0) && (ks_q2 == '0);
    sing_q[4] <= sing_q[3];
    sing_q[5] <= sing_q[4];
  end

  logic signed [28:0] kc_q4, ks_q4;
  always_ff @(posedge clk) begin
    kc_q4 <= kcn_q3 ? -29'(kcm_q3 >> k_q3) : 29'(kcm_q3 >> k_q3);
    ks_q4 <= 29'(ks_q3 >> k_q3);
  end

  // Rotate the target into the elbow frame
  logic signed [53:0] kx_q5, sy_q5, ky_q5, sx_q5;
  always_ff @(posedge clk) begin
    kx_q5 <= 54'(kc_q4 * tq[4].x);
    sy_q5 <= 54'(ks_q4 * tq[4].y);
    ky_q5 <= 54'(kc_q4 * tq[4].y);
    sx_q5 <= 54'(ks_q4 * tq[4].x);
  end

  logic signed [55:0] cx_q6, sn_q6;
  logic               sing_q6;
  always_ff @(posedge clk) begin
    cx_q6   <= 56'(kx_q5) + 56'(sy_q5);
    sn_q6   <= 56'(ky_q5) - 56'(sx_q5);
    sing_q6 <= sing_q[5];
  end

  // Scale the atan2 operands below 2^30
  logic [54:0] cxm, snm;
  assign cxm = cx_q6[55] ? 55'(-cx_q6) : 55'(cx_q6);
  assign snm = sn_q6[55] ? 55'(-sn_q6) : 55'(sn_q6);

  logic [54:0] cxm_q7, snm_q7;
  logic        cxn_q7, snn_q7, sing_q7;
  logic [6:0]  k_q7;
  always_ff @(posedge clk) begin
    cxm_q7  <= cxm;
    snm_q7  <= snm;
    cxn_q7  <= cx_q6[55];
    snn_q7  <= sn_q6[55];
    k_q7    <= ikl_pkg::shrink_k(64'(cxm | snm), 7'd30);
    sing_q7 <= sing_q6;
  end

  logic signed [OW-1:0] cx_q8, sn_q8;
  ikl_pkg::cd_tag_t     cdt_q8;
  always_ff @(posedge clk) begin
    cx_q8           <= cxn_q7 ? -OW'(cxm_q7 >> k_q7) : OW'(cxm_q7 >> k_q7);
    sn_q8           <= snn_q7 ? -OW'(snm_q7 >> k_q7) : OW'(snm_q7 >> k_q7);
    cdt_q8.clamped  <= tq[7].clamped;
    cdt_q8.aneg     <= tq[7].aneg;
    cdt_q8.singular <= sing_q7;
  end

  // Shoulder and elbow atan2 run side by side
  logic                           sh_vld, el_vld;
  logic signed [ikl_pkg::CD_W-1:0] sh_z, el_z;
  ikl_pkg::cd_tag_t               sh_tag, el_tag;

  ikl_cordic #(.STAGES(CORDIC_STAGES)) u_shoulder (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vq[8]),
    .in_y      (sn_q8),
    .in_x      (cx_q8),
    .in_tag    (cdt_q8),
    .out_valid (sh_vld),
    .out_z     (sh_z),
    .out_tag   (sh_tag)
  );

  ikl_cordic #(.STAGES(CORDIC_STAGES)) u_elbow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vq[8]),
    .in_y      ($signed({1'b0, sr_q[8]})),
    .in_x      (tq[8].a_s),
    .in_tag    (cdt_q8),
    .out_valid (el_vld),
    .out_z     (el_z),
    .out_tag   (el_tag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= sh_vld && el_vld;
  end

  always_ff @(posedge clk) begin
    result.shoulder_angle <= sh_tag.singular ? '0 : ikl_pkg::to_angle(sh_z);
    if (el_tag.clamped)
      result.elbow_angle <= el_tag.aneg ? ikl_pkg::ANGLE_W'(ikl_pkg::ANG_LIM) : '0;
    else
      result.elbow_angle <= ikl_pkg::to_angle(el_z);
    result.solve_status <= sh_tag.singular ? ikl_pkg::ST_SINGULAR
                         : (sh_tag.clamped ? ikl_pkg::ST_CLAMPED : ikl_pkg::ST_SOLVED);
  end

  // Checks
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.solve_status == ikl_pkg::ST_SINGULAR
      |-> result.shoulder_angle == '0)
    else $error("singular result with nonzero shoulder angle");

  a_clamp_elbow: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.solve_status == ikl_pkg::ST_CLAMPED
      |-> result.elbow_angle == '0
       || result.elbow_angle == ikl_pkg::ANGLE_W'(ikl_pkg::ANG_LIM))
    else $error("clamped elbow angle is neither zero nor pi");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    sh_vld == el_vld)
    else $error("shoulder and elbow pipelines out of step");

  a_angle_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $signed(result.shoulder_angle) <= $signed(ikl_pkg::ANG_LIM)
                  && $signed(result.shoulder_angle) >= -$signed(ikl_pkg::ANG_LIM))
    else $error("shoulder angle beyond pi");

endmodule
